### rtl/core/rbce_pkg.sv
// Package for the rotated box corner engine.
// Holds coordinate and trig types, mode and register codes, the quarter-wave sine
// table and the saturation and scaling helpers. Depends on nothing.
package rbce_pkg;

  localparam int COORD_BITS     = 16;
  localparam int SIZE_BITS      = 15;
  localparam int ANGLE_BITS     = 9;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int TRIG_BITS      = TRIG_FRAC_BITS + 2;
  localparam int OFFS_BITS      = COORD_BITS + 2;
  localparam int PROD_BITS      = OFFS_BITS + TRIG_BITS;
  localparam int SUM_BITS       = COORD_BITS + 4;
  localparam int QSIN_BITS      = TRIG_FRAC_BITS + 1;
  localparam int QIDX_BITS      = 7;
  localparam int FULL_TURN      = 360;
  localparam int QUARTER_TURN   = 90;
  localparam int RESET_BOX_SIZE = 16;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TRIG_BITS-1:0]  trig_t;
  typedef logic signed [OFFS_BITS-1:0]  offs_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [SIZE_BITS-1:0]         size_t;
  typedef logic [ANGLE_BITS-1:0]        angle_t;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_MOVE   = 2'd1,
    MODE_ROTATE = 2'd2,
    MODE_HOLD   = 2'd3
  } mode_t;

  typedef enum logic {
    REG_BOX_WIDTH  = 1'b0,
    REG_BOX_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    trig_t sin_val;
    trig_t cos_val;
  } trig_pair_t;

  localparam sum_t   COORD_MAX  = sum_t'((2 ** (COORD_BITS - 1)) - 1);
  localparam sum_t   COORD_MIN  = sum_t'(-(2 ** (COORD_BITS - 1)));
  localparam prod_t  TRUNC_BIAS = prod_t'((2 ** TRIG_FRAC_BITS) - 1);
  localparam trig_t  TRIG_ONE   = trig_t'(2 ** TRIG_FRAC_BITS);
  localparam coord_t BOX_RESET  = coord_t'(RESET_BOX_SIZE);
  localparam coord_t PIVOT_RESET = coord_t'(RESET_BOX_SIZE / 2);

  // round(sin(k degrees) * 2^14) for k = 0 .. 90.
  localparam logic [QSIN_BITS-1:0] QUARTER_SINE [0:QUARTER_TURN] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  function automatic coord_t sat_coord(input sum_t v);
    coord_t res;
    if (v > COORD_MAX) begin
      res = coord_t'(COORD_MAX);
    end else if (v < COORD_MIN) begin
      res = coord_t'(COORD_MIN);
    end else begin
      res = coord_t'(v);
    end
    return res;
  endfunction

  // Drops the fraction bits of a product, rounding toward zero.
  function automatic sum_t trunc_scale(input prod_t p);
    prod_t biased;
    biased = p + (p[PROD_BITS-1] ? TRUNC_BIAS : prod_t'(0));
    return sum_t'(biased >>> TRIG_FRAC_BITS);
  endfunction

  // Sine and cosine of an angle in degrees; angles past a full turn wrap once.
  function automatic trig_pair_t trig_lookup(input angle_t ang);
    angle_t         a;
    logic [1:0]     q;
    logic [QIDX_BITS-1:0] r;
    trig_t          t_r;
    trig_t          t_c;
    trig_pair_t     res;
    a = (ang >= angle_t'(FULL_TURN)) ? ang - angle_t'(FULL_TURN) : ang;
    if (a < angle_t'(QUARTER_TURN)) begin
      q = 2'd0;
      r = QIDX_BITS'(a);
    end else if (a < angle_t'(2 * QUARTER_TURN)) begin
      q = 2'd1;
      r = QIDX_BITS'(a - angle_t'(QUARTER_TURN));
    end else if (a < angle_t'(3 * QUARTER_TURN)) begin
      q = 2'd2;
      r = QIDX_BITS'(a - angle_t'(2 * QUARTER_TURN));
    end else begin
      q = 2'd3;
      r = QIDX_BITS'(a - angle_t'(3 * QUARTER_TURN));
    end
    t_r = trig_t'(QUARTER_SINE[r]);
    t_c = trig_t'(QUARTER_SINE[QIDX_BITS'(QUARTER_TURN) - r]);
    case (q)
      2'd0: begin
        res.sin_val = t_r;
        res.cos_val = t_c;
      end
      2'd1: begin
        res.sin_val = t_c;
        res.cos_val = -t_r;
      end
      2'd2: begin
        res.sin_val = -t_r;
        res.cos_val = -t_c;
      end
      default: begin
        res.sin_val = -t_c;
        res.cos_val = t_r;
      end
    endcase
    return res;
  endfunction

endpackage

### rtl/core/rotated_box_corner_engine_top.sv
// Top level of the rotated box corner engine.
// Depends on rbce_pkg for types, codes, the sine table and arithmetic helpers.
//
// Usage: a request on the input channel (in_valid/in_ready) carries mode, arg_x,
// arg_y and angle. Set places the anchor corner, move shifts it by (arg_x, arg_y),
// rotate sets the angle, and the unused mode code leaves everything as it is.
// Every request returns one result on the output channel (out_valid/out_ready)
// with all four rotated corners.
// The first stage updates the anchor, center and sine/cosine registers; the second
// runs eight 18x16 multipliers and writes the corner registers, which drive the
// outputs directly. One request per cycle is sustained while out_ready stays high.
// When the receiver stalls, the result and the corners hold; one more request is
// taken into the first stage, after which in_ready drops until the result is taken.
// The user must write box width and height through cfg_write/cfg_index/cfg_data
// only while the engine is idle; the block does not enforce it. Synchronous reset
// restores a 16 by 16 box at the origin, angle zero, with no result pending.
module rotated_box_corner_engine_top import rbce_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   mode,
  input  coord_t       arg_x,
  input  coord_t       arg_y,
  input  angle_t       angle,
  output logic         out_valid,
  input  logic         out_ready,
  output coord_t       corner0_x,
  output coord_t       corner0_y,
  output coord_t       corner1_x,
  output coord_t       corner1_y,
  output coord_t       corner2_x,
  output coord_t       corner2_y,
  output coord_t       corner3_x,
  output coord_t       corner3_y,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  size_t        cfg_data
);

  size_t      box_width;
  size_t      box_height;
  coord_t     anchor_x;
  coord_t     anchor_y;
  coord_t     pivot_x;
  coord_t     pivot_y;
  trig_t      sin_val;
  trig_t      cos_val;
  logic       s1_valid;
  logic       s1_hold;
  coord_t     corner_x [4];
  coord_t     corner_y [4];

  coord_t     anchor_x_next;
  coord_t     anchor_y_next;
  coord_t     pivot_x_next;
  coord_t     pivot_y_next;
  trig_pair_t trig_next;
  coord_t     corner_x_next [4];
  coord_t     corner_y_next [4];
  offs_t      ox [2];
  offs_t      oy [2];
  sum_t       ox_c [2];
  sum_t       ox_s [2];
  sum_t       oy_c [2];
  sum_t       oy_s [2];
  logic       in_fire;
  logic       s1_adv;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= size_t'(RESET_BOX_SIZE);
      box_height <= size_t'(RESET_BOX_SIZE);
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_BOX_WIDTH:  box_width  <= cfg_data;
        REG_BOX_HEIGHT: box_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // First stage: anchor, center and angle.
  always_comb begin
    if (mode_t'(mode) == MODE_SET) begin
      anchor_x_next = arg_x;
      anchor_y_next = arg_y;
    end else begin
      anchor_x_next = sat_coord(sum_t'(anchor_x) + sum_t'(arg_x));
      anchor_y_next = sat_coord(sum_t'(anchor_y) + sum_t'(arg_y));
    end
    pivot_x_next = sat_coord(sum_t'(anchor_x_next) + sum_t'(box_width >> 1));
    pivot_y_next = sat_coord(sum_t'(anchor_y_next) + sum_t'(box_height >> 1));
    trig_next    = trig_lookup(angle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x <= '0;
      anchor_y <= '0;
      pivot_x  <= PIVOT_RESET;
      pivot_y  <= PIVOT_RESET;
      sin_val  <= '0;
      cos_val  <= TRIG_ONE;
    end else if (in_fire) begin
      unique case (mode_t'(mode)) inside
        MODE_SET, MODE_MOVE: begin
          anchor_x <= anchor_x_next;
          anchor_y <= anchor_y_next;
          pivot_x  <= pivot_x_next;
          pivot_y  <= pivot_y_next;
        end
        MODE_ROTATE: begin
          sin_val <= trig_next.sin_val;
          cos_val <= trig_next.cos_val;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_hold <= (mode_t'(mode) == MODE_HOLD);
    end
  end

  // Second stage: offsets from the center, turned by the stored angle.
  // Index 0 is the anchor side of the box, index 1 the far side.
  always_comb begin
    ox[0] = offs_t'(anchor_x) - offs_t'(pivot_x);
    oy[0] = offs_t'(anchor_y) - offs_t'(pivot_y);
    ox[1] = ox[0] + offs_t'(box_width);
    oy[1] = oy[0] + offs_t'(box_height);
    for (int k = 0; k < 2; k++) begin
      ox_c[k] = trunc_scale(prod_t'(ox[k]) * prod_t'(cos_val));
      ox_s[k] = trunc_scale(prod_t'(ox[k]) * prod_t'(sin_val));
      oy_c[k] = trunc_scale(prod_t'(oy[k]) * prod_t'(cos_val));
      oy_s[k] = trunc_scale(prod_t'(oy[k]) * prod_t'(sin_val));
    end
  end

  // Corners run anchor, right, far, bottom: x side is far for corners one and
  // two, y side is far for corners two and three.
  always_comb begin
    logic [1:0] idx;
    logic       xi;
    logic       yi;
    for (int i = 0; i < 4; i++) begin
      idx = 2'(i);
      xi  = idx[0] ^ idx[1];
      yi  = idx[1];
      corner_x_next[i] = sat_coord(sum_t'(pivot_x) + ox_c[xi] - oy_s[yi]);
      corner_y_next[i] = sat_coord(sum_t'(pivot_y) + ox_s[xi] + oy_c[yi]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_x[0] <= '0;
      corner_y[0] <= '0;
      corner_x[1] <= BOX_RESET;
      corner_y[1] <= '0;
      corner_x[2] <= BOX_RESET;
      corner_y[2] <= BOX_RESET;
      corner_x[3] <= '0;
      corner_y[3] <= BOX_RESET;
    end else if (s1_adv && !s1_hold) begin
      corner_x <= corner_x_next;
      corner_y <= corner_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign corner0_x = corner_x[0];
  assign corner0_y = corner_y[0];
  assign corner1_x = corner_x[1];
  assign corner1_y = corner_y[1];
  assign corner2_x = corner_x[2];
  assign corner2_y = corner_y[2];
  assign corner3_x = corner_x[3];
  assign corner3_y = corner_y[3];

endmodule

### rtl/core/rbce_checker.sv
// Port-level checks for the rotated box corner engine, bound to its top level.
// Depends on rbce_pkg and on the port list of rotated_box_corner_engine_top.
module rbce_checker import rbce_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t corner0_x,
  input coord_t corner0_y,
  input coord_t corner1_x,
  input coord_t corner1_y,
  input coord_t corner2_x,
  input coord_t corner2_y,
  input coord_t corner3_x,
  input coord_t corner3_y
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its corners.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(corner0_x) && $stable(corner0_y) &&
      $stable(corner1_x) && $stable(corner1_y) && $stable(corner2_x) &&
      $stable(corner2_y) && $stable(corner3_x) && $stable(corner3_y))
    else $error("corners changed while stalled");

  // With the output side free, the engine always takes a request.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("request refused with output side free");

  // An accepted request shows up as a result if the output side is free once the first stage holds it.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("accepted request produced no result");

  // Reset leaves the unrotated default box and no result pending.
  assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid && corner0_x == '0 && corner1_x == BOX_RESET &&
      corner2_y == BOX_RESET && corner3_x == '0)
    else $error("wrong state after reset");

endmodule

bind rotated_box_corner_engine_top rbce_checker u_rbce_checker (.*);

### sim/testbench.sv
// Self-checking testbench for rotated_box_corner_engine_top.
// Needs only rbce_pkg for port types and codes; a corner tracker class predicts every
// result, tasks drive requests and box size writes, and out_ready stalls at random.
`timescale 1ns / 100ps

module testbench;
  import rbce_pkg::*;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam int FRAC         = 14;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int CHUNKS       = 17;
  localparam int CHUNK_ITEMS  = 50;

  typedef struct packed {
    coord_t [3:0] cx;
    coord_t [3:0] cy;
  } corner_set_t;

  class corner_tracker;
    longint      wid, hgt;
    longint      anc_x, anc_y, piv_x, piv_y;
    int unsigned cur_ang;
    longint      rx [4];
    longint      ry [4];
    longint      sine_tab [91];
    corner_set_t expected_corners [$];
    int          errors;

    function new();
      longint unsigned x, x2, term, sum_u;
      longint          sum;
      sine_tab[0] = 0;
      sine_tab[90] = longint'(1) << FRAC;
      // Taylor series in Q30, rounded to nearest at the table precision.
      for (int r = 1; r < 90; r++) begin
        x = (longint'(r) * PI_Q30 + 90) / 180;
        x2 = (x * x) >> 30;
        sum = longint'(x);
        term = x;
        for (int k = 1; k < 20 && term != 0; k++) begin
          term = (term * x2) >> 30;
          term = term / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        sum_u = sum;
        if (sum_u > ONE_Q30) sum_u = ONE_Q30;
        sine_tab[r] = longint'(((sum_u >> (29 - FRAC)) + 1) >> 1);
      end
      wid = RESET_BOX_SIZE;
      hgt = RESET_BOX_SIZE;
      anc_x = 0;
      anc_y = 0;
      cur_ang = 0;
      errors = 0;
      recenter();
      rerotate();
    endfunction

    function longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint sine_of(int unsigned a);
      int unsigned q, r;
      q = (a % 360) / 90;
      r = (a % 360) % 90;
      case (q)
        0: return sine_tab[r];
        1: return sine_tab[90 - r];
        2: return -sine_tab[r];
        default: return -sine_tab[90 - r];
      endcase
    endfunction

    // Product scaled down by the fraction bits, rounding toward zero.
    function longint drop_frac(longint v);
      if (v >= 0) return v >>> FRAC;
      return -((-v) >>> FRAC);
    endfunction

    function void recenter();
      piv_x = clamp16(anc_x + wid / 2);
      piv_y = clamp16(anc_y + hgt / 2);
    endfunction

    function void rerotate();
      longint s, c, ox, oy;
      s = sine_of(cur_ang);
      c = sine_of(cur_ang + 90);
      for (int i = 0; i < 4; i++) begin
        ox = anc_x + ((i == 1 || i == 2) ? wid : 0) - piv_x;
        oy = anc_y + ((i >= 2) ? hgt : 0) - piv_y;
        rx[i] = clamp16(piv_x + drop_frac(ox * c) - drop_frac(oy * s));
        ry[i] = clamp16(piv_y + drop_frac(ox * s) + drop_frac(oy * c));
      end
    endfunction

    // A size change leaves the state alone until the next set, move or rotate request.
    function void resize(size_t w, size_t h);
      wid = w;
      hgt = h;
    endfunction

    function void note_request(mode_t m, coord_t x, coord_t y, angle_t a);
      corner_set_t e;
      case (m)
        MODE_SET: begin
          anc_x = x;
          anc_y = y;
          recenter();
          rerotate();
        end
        MODE_MOVE: begin
          anc_x = clamp16(anc_x + longint'(x));
          anc_y = clamp16(anc_y + longint'(y));
          recenter();
          rerotate();
        end
        MODE_ROTATE: begin
          cur_ang = int'(a) % 360;
          rerotate();
        end
        default: begin
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        e.cx[i] = coord_t'(rx[i]);
        e.cy[i] = coord_t'(ry[i]);
      end
      expected_corners.push_back(e);
    endfunction

    function void check_result(corner_set_t got);
      corner_set_t e;
      if (expected_corners.size() == 0) begin
        $display("%0t: corner result with no request outstanding", $time);
        errors++;
        return;
      end
      e = expected_corners.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got.cx[i] !== e.cx[i]) begin
          $display("%0t: corner%0d_x expected %0d, actual %0d", $time, i,
                   $signed(e.cx[i]), $signed(got.cx[i]));
          errors++;
        end
        if (got.cy[i] !== e.cy[i]) begin
          $display("%0t: corner%0d_y expected %0d, actual %0d", $time, i,
                   $signed(e.cy[i]), $signed(got.cy[i]));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_corners.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] mode;
  coord_t     arg_x;
  coord_t     arg_y;
  angle_t     angle;
  logic       out_valid;
  logic       out_ready;
  coord_t     corner0_x, corner0_y, corner1_x, corner1_y;
  coord_t     corner2_x, corner2_y, corner3_x, corner3_y;
  logic       cfg_write;
  logic       cfg_index;
  size_t      cfg_data;

  corner_tracker board = new();
  int feed_gap_pct;
  int sink_stall_pct;
  int cycle_count = 0;

  rotated_box_corner_engine_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .arg_x(arg_x), .arg_y(arg_y), .angle(angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .corner0_x(corner0_x), .corner0_y(corner0_y),
    .corner1_x(corner1_x), .corner1_y(corner1_y),
    .corner2_x(corner2_x), .corner2_y(corner2_y),
    .corner3_x(corner3_x), .corner3_y(corner3_y),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Result side: check what was taken at this edge, then pick the next ready.
  always @(posedge clk) begin
    corner_set_t got;
    if (!rst && out_valid && out_ready) begin
      got.cx[0] = corner0_x;
      got.cy[0] = corner0_y;
      got.cx[1] = corner1_x;
      got.cy[1] = corner1_y;
      got.cx[2] = corner2_x;
      got.cy[2] = corner2_y;
      got.cx[3] = corner3_x;
      got.cy[3] = corner3_y;
      board.check_result(got);
    end
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_request(input mode_t m, input coord_t x, input coord_t y,
                              input angle_t a);
    while ($urandom_range(99) < feed_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    arg_x <= x;
    arg_y <= y;
    angle <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(m, x, y, a);
  endtask

  // Sampling on the falling edge keeps clear of the checker's pops.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_box_size(input size_t w, input size_t h);
    cfg_write <= 1'b1;
    cfg_index <= REG_BOX_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_BOX_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.resize(w, h);
  endtask

  function automatic coord_t pick_coord();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return coord_t'(int'($urandom_range(4000)) - 2000);
    if (sel < 80) return coord_t'($urandom);
    if (sel < 90) return coord_t'(32767 - int'($urandom_range(300)));
    return coord_t'(-32768 + int'($urandom_range(300)));
  endfunction

  function automatic angle_t pick_angle();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return angle_t'($urandom_range(359));
    if (sel < 90) return angle_t'(90 * $urandom_range(3));
    return angle_t'($urandom_range(511, 360));
  endfunction

  initial begin
    mode_t       m;
    int unsigned sel;
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= MODE_HOLD;
    arg_x <= '0;
    arg_y <= '0;
    angle <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_BOX_WIDTH;
    cfg_data <= '0;
    out_ready <= 1'b0;
    feed_gap_pct = 30;
    sink_stall_pct = 73;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset box, angle wrap, coordinate saturation, unused mode.
    send_request(MODE_HOLD, 16'sd5, -16'sd5, 9'd77);
    send_request(MODE_ROTATE, 0, 0, 9'd90);
    send_request(MODE_ROTATE, 0, 0, 9'd45);
    send_request(MODE_ROTATE, 0, 0, 9'd359);
    send_request(MODE_ROTATE, 0, 0, 9'd360);
    send_request(MODE_ROTATE, 0, 0, 9'd511);
    send_request(MODE_SET, 16'sh7fff, 16'sh7fff, 9'd0);
    send_request(MODE_SET, -16'sh8000, -16'sh8000, 9'h1ff);
    send_request(MODE_MOVE, -16'sh8000, -16'sh8000, 9'd0);
    send_request(MODE_MOVE, 16'sh7fff, 16'sh7fff, 9'd0);
    send_request(MODE_MOVE, 16'sh7fff, 16'sh7fff, 9'd0);
    send_request(MODE_ROTATE, 0, 0, 9'd180);
    send_request(MODE_ROTATE, 0, 0, 9'd270);
    send_request(MODE_SET, 16'sd100, -16'sd100, 9'd0);
    send_request(MODE_MOVE, 16'sd5, -16'sd7, 9'd0);
    send_request(MODE_HOLD, 0, 0, 9'd0);
    // A new size shows in the offsets first and in the center only after set or move.
    wait_for_drain();
    set_box_size(15'd32767, 15'd0);
    send_request(MODE_HOLD, 0, 0, 9'd0);
    send_request(MODE_ROTATE, 0, 0, 9'd30);
    send_request(MODE_MOVE, 0, 0, 9'd0);
    send_request(MODE_SET, -16'sd1, -16'sd1, 9'd0);
    wait_for_drain();
    set_box_size(15'd0, 15'd32767);
    send_request(MODE_SET, 16'sh7fff, -16'sh8000, 9'd0);
    send_request(MODE_ROTATE, 0, 0, 9'd225);

    for (int c = 0; c < CHUNKS; c++) begin
      wait_for_drain();
      if (c < CHUNKS / 3) begin
        feed_gap_pct = 30;
        sink_stall_pct = 73;
      end else if (c < 2 * CHUNKS / 3) begin
        feed_gap_pct = 73;
        sink_stall_pct = 30;
      end else begin
        feed_gap_pct = 0;
        sink_stall_pct = 0;
      end
      case (c % 6)
        0: set_box_size(15'd16, 15'd16);
        1: set_box_size(15'd0, 15'd0);
        2: set_box_size(15'd32767, 15'd32767);
        3: set_box_size(size_t'($urandom_range(200)), size_t'($urandom_range(200)));
        4: set_box_size(15'd1, 15'd32767);
        default: set_box_size(size_t'($urandom_range(32767)), size_t'($urandom_range(32767)));
      endcase
      // Each stretch starts by placing the box, then moves and turns it.
      send_request(MODE_SET, pick_coord(), pick_coord(), angle_t'($urandom));
      for (int n = 1; n < CHUNK_ITEMS; n++) begin
        sel = $urandom_range(99);
        if (sel < 20) m = MODE_SET;
        else if (sel < 55) m = MODE_MOVE;
        else if (sel < 92) m = MODE_ROTATE;
        else m = MODE_HOLD;
        send_request(m, pick_coord(), pick_coord(), pick_angle());
      end
    end

    wait_for_drain();
    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
